[hdl/scpz_pkg.sv]
// Shared types and constants for the z-order sorted cell pool.
// Depends on nothing; every other file imports it.
package scpz_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int COORD_BITS_DEF = 16;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_GET    = 2'd1,
        OP_MARK   = 2'd2,
        OP_SORT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_VALID    = 2'd1,
        ST_DANGLING = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        op_t                op;
        logic               handle_valid;
        logic [7:0]         handle_id;
        logic signed [15:0] point_i;
        logic signed [15:0] point_j;
        logic signed [15:0] point_k;
        logic               cell_empty;
    } req_word_t;

    typedef struct packed {
        logic [7:0]         cell_id;
        logic [7:0]         slot;
        logic signed [15:0] out_i;
        logic signed [15:0] out_j;
        logic signed [15:0] out_k;
        logic               reused;
        status_t            status;
    } rsp_word_t;

    typedef enum logic [1:0] {RD_N, RD_M1, RD_IDX} rd_sel_t;
    typedef enum logic [2:0] {WR_REUSE, WR_APPEND, WR_MARK, WR_SHIFT, WR_X} wr_sel_t;
    typedef enum logic {IDX_APPEND, IDX_REBUILD} idx_sel_t;
    typedef enum logic [2:0] {
        RES_REUSE, RES_APPEND, RES_FULL, RES_UNKNOWN, RES_LOOKUP, RES_SORT
    } res_sel_t;

    typedef struct packed {
        logic     cap;
        logic     n_clr;
        logic     n_one;
        logic     n_inc;
        logic     m_load;
        logic     m_dec;
        logic     x_load;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     idx_rd;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     idx_wr;
        idx_sel_t idx_sel;
        logic     cnt_inc;
        logic     res_en;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic handle_valid;
        logic known;
        logic n_ge;
        logic m_zero;
        logic full;
        logic is_free;
        logic ahead;
        logic out_free;
    } sts_t;

endpackage

[hdl/scpz_if.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on scpz_pkg for the payload types.
interface scpz_req_if import scpz_pkg::*; ();
    logic      valid;
    logic      ready;
    req_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface scpz_rsp_if import scpz_pkg::*; ();
    logic      valid;
    logic      ready;
    rsp_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/scpz_datapath.sv]
// Datapath: slot memory, id index memory, counters, comparator, result registers.
// Depends on scpz_pkg; driven by scpz_ctrl through cmd_t / sts_t.
module scpz_datapath import scpz_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    output sts_t      sts,
    input  req_word_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CB = COORD_BITS;
    localparam int W  = 3 * CB + IW + 1;
    localparam logic [CB-1:0] FLIP = {1'b1, {(CB-1){1'b0}}};

    logic [W-1:0]  slot_mem [CAPACITY];
    logic [IW-1:0] idx_mem  [CAPACITY];

    logic [W-1:0]  rd_reg;
    logic [IW-1:0] idx_rd_reg;
    logic [W-1:0]  x_reg;
    logic [IW:0]   count_reg, n_reg;
    logic [IW-1:0] m_reg;
    req_word_t     item_reg;
    rsp_word_t     res_reg, out_reg;
    logic          out_valid_reg;

    logic [IW-1:0]  ra, wa, ia;
    logic [W-1:0]   wd;
    logic [IW-1:0]  id_w, iwa, iwd;
    logic [IW+7:0]  id_pad;
    logic [3*CB-1:0] pt_in;
    logic signed [31:0] wi, wj, wk;
    rsp_word_t      res_next;

    function automatic logic [7:0] to8(input logic [IW-1:0] v);
        logic [IW+7:0] e;
        e = {8'd0, v};
        return e[7:0];
    endfunction

    function automatic logic signed [15:0] give(input logic [CB-1:0] v);
        logic signed [31:0] w;
        w = 32'(signed'(v));
        return w[15:0];
    endfunction

    function automatic logic msb_below(input logic [CB-1:0] x, input logic [CB-1:0] y);
        return (x < y) && (x < (x ^ y));
    endfunction

    // field views of words
    function automatic logic [CB-1:0] crd(input logic [W-1:0] w, input int d);
        return w[W-1-d*CB -: CB];
    endfunction

    // sign-extend or truncate the input point to the stored width
    assign wi    = 32'(item_reg.point_i);
    assign wj    = 32'(item_reg.point_j);
    assign wk    = 32'(item_reg.point_k);
    assign pt_in = {wi[CB-1:0], wj[CB-1:0], wk[CB-1:0]};

    assign id_pad = {{IW{1'b0}}, item_reg.handle_id};
    assign id_w   = id_pad[IW-1:0];

    // z-order comparator: does x_reg go ahead of rd_reg
    logic [CB-1:0] a0, a1, a2, b0, b1, b2, d0, d1, d2, dt, at, bt;
    logic          s1, s2, x_ahead;
    always_comb
    begin
        a0 = crd(x_reg, 0) ^ FLIP;
        a1 = crd(x_reg, 1) ^ FLIP;
        a2 = crd(x_reg, 2) ^ FLIP;
        b0 = crd(rd_reg, 0) ^ FLIP;
        b1 = crd(rd_reg, 1) ^ FLIP;
        b2 = crd(rd_reg, 2) ^ FLIP;
        d0 = a0 ^ b0;
        d1 = a1 ^ b1;
        d2 = a2 ^ b2;
        s1 = msb_below(d0, d1);
        dt = s1 ? d1 : d0;
        s2 = msb_below(dt, d2);
        at = s2 ? a2 : (s1 ? a1 : a0);
        bt = s2 ? b2 : (s1 ? b1 : b0);
        if (x_reg[0] != rd_reg[0])
            x_ahead = !x_reg[0];
        else if (!x_reg[0] && (at != bt))
            x_ahead = at < bt;
        else
            x_ahead = x_reg[IW:1] < rd_reg[IW:1];
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_N:    ra = n_reg[IW-1:0];
            RD_M1:   ra = m_reg - 1'b1;
            RD_IDX:  ra = idx_rd_reg;
            default: ra = n_reg[IW-1:0];
        endcase
        unique case (cmd.wr_sel)
            WR_REUSE:
            begin
                wa = n_reg[IW-1:0];
                wd = {pt_in, rd_reg[IW:1], 1'b0};
            end
            WR_APPEND:
            begin
                wa = count_reg[IW-1:0];
                wd = {pt_in, count_reg[IW-1:0], 1'b0};
            end
            WR_MARK:
            begin
                wa = idx_rd_reg;
                wd = {rd_reg[W-1:1], item_reg.cell_empty};
            end
            WR_SHIFT:
            begin
                wa = m_reg;
                wd = rd_reg;
            end
            default:
            begin
                wa = m_reg;
                wd = x_reg;
            end
        endcase
        unique case (cmd.idx_sel)
            IDX_APPEND:
            begin
                iwa = count_reg[IW-1:0];
                iwd = count_reg[IW-1:0];
            end
            default:
            begin
                iwa = rd_reg[IW:1];
                iwd = n_reg[IW-1:0];
            end
        endcase
        ia = id_w;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            slot_mem[wa] <= wd;
        if (cmd.rd_en)
            rd_reg <= slot_mem[ra];
        if (cmd.idx_wr)
            idx_mem[iwa] <= iwd;
        if (cmd.idx_rd)
            idx_rd_reg <= idx_mem[ia];
    end

    always_comb
    begin
        res_next = '0;
        unique case (cmd.res_sel)
            RES_REUSE:
            begin
                res_next.cell_id = to8(rd_reg[IW:1]);
                res_next.slot    = to8(n_reg[IW-1:0]);
                res_next.out_i   = give(pt_in[3*CB-1 -: CB]);
                res_next.out_j   = give(pt_in[2*CB-1 -: CB]);
                res_next.out_k   = give(pt_in[CB-1:0]);
                res_next.reused  = 1'b1;
            end
            RES_APPEND:
            begin
                res_next.cell_id = to8(count_reg[IW-1:0]);
                res_next.slot    = to8(count_reg[IW-1:0]);
                res_next.out_i   = give(pt_in[3*CB-1 -: CB]);
                res_next.out_j   = give(pt_in[2*CB-1 -: CB]);
                res_next.out_k   = give(pt_in[CB-1:0]);
            end
            RES_FULL:
                res_next.status = ST_FULL;
            RES_UNKNOWN:
            begin
                res_next.cell_id = item_reg.handle_id;
                res_next.status  = ST_DANGLING;
            end
            RES_LOOKUP:
            begin
                res_next.cell_id = to8(rd_reg[IW:1]);
                res_next.slot    = to8(idx_rd_reg);
                res_next.out_i   = give(crd(rd_reg, 0));
                res_next.out_j   = give(crd(rd_reg, 1));
                res_next.out_k   = give(crd(rd_reg, 2));
                unique case (item_reg.op)
                    OP_CREATE: res_next.status = ST_VALID;
                    OP_GET:    res_next.status = item_reg.handle_valid ? ST_OK : ST_DANGLING;
                    default:   res_next.status = ST_OK;
                endcase
            end
            default:
                res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
            item_reg <= req_data;
        if (cmd.x_load)
            x_reg <= rd_reg;
        if (cmd.res_en)
            res_reg <= res_next;
        if (cmd.out_load)
            out_reg <= res_reg;
        if (cmd.m_load)
            m_reg <= n_reg[IW-1:0];
        else if (cmd.m_dec)
            m_reg <= m_reg - 1'b1;
        if (cmd.n_clr)
            n_reg <= '0;
        else if (cmd.n_one)
            n_reg <= (IW+1)'(1);
        else if (cmd.n_inc)
            n_reg <= n_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
                count_reg <= count_reg + 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    assign sts.op           = item_reg.op;
    assign sts.handle_valid = item_reg.handle_valid;
    assign sts.known        = {{(IW+1){1'b0}}, item_reg.handle_id} < {8'd0, count_reg};
    assign sts.n_ge         = n_reg >= count_reg;
    assign sts.m_zero       = m_reg == '0;
    assign sts.full         = count_reg == (IW+1)'(CAPACITY);
    assign sts.is_free      = rd_reg[0];
    assign sts.ahead        = x_ahead;
    assign sts.out_free     = !out_valid_reg || rsp_ready;

endmodule

[hdl/scpz_ctrl.sv]
// Controller state machine: sequences create scan, lookup, insertion sort, index rebuild.
// Depends on scpz_pkg; commands scpz_datapath.
module scpz_ctrl import scpz_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_DISPATCH  = 15'b000000000000010,
        S_SCAN_RD   = 15'b000000000000100,
        S_SCAN_CHK  = 15'b000000000001000,
        S_APPEND    = 15'b000000000010000,
        S_LOOK_RD   = 15'b000000000100000,
        S_LOOK_SLOT = 15'b000000001000000,
        S_LOOK_DONE = 15'b000000010000000,
        S_SORT_N    = 15'b000000100000000,
        S_SORT_LD   = 15'b000001000000000,
        S_SORT_RD   = 15'b000010000000000,
        S_SORT_CMP  = 15'b000100000000000,
        S_REB_RD    = 15'b001000000000000,
        S_REB_W     = 15'b010000000000000,
        S_DONE      = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    assign req_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (req_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_DISPATCH;
                end
            S_DISPATCH:
                if (sts.op == OP_SORT)
                begin
                    cmd.n_one  = 1'b1;
                    state_next = S_SORT_N;
                end
                else if (sts.op == OP_CREATE && !sts.handle_valid)
                begin
                    cmd.n_clr  = 1'b1;
                    state_next = S_SCAN_RD;
                end
                else
                    state_next = S_LOOK_RD;
            S_SCAN_RD:
                if (sts.n_ge)
                    state_next = S_APPEND;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_N;
                    state_next = S_SCAN_CHK;
                end
            S_SCAN_CHK:
                if (sts.is_free)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_REUSE;
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_REUSE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.n_inc  = 1'b1;
                    state_next = S_SCAN_RD;
                end
            S_APPEND:
            begin
                cmd.res_en = 1'b1;
                state_next = S_DONE;
                if (sts.full)
                    cmd.res_sel = RES_FULL;
                else
                begin
                    cmd.res_sel = RES_APPEND;
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_APPEND;
                    cmd.idx_wr  = 1'b1;
                    cmd.idx_sel = IDX_APPEND;
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_LOOK_RD:
                if (!sts.known)
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_UNKNOWN;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.idx_rd = 1'b1;
                    state_next = S_LOOK_SLOT;
                end
            S_LOOK_SLOT:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
                state_next = S_LOOK_DONE;
            end
            S_LOOK_DONE:
            begin
                cmd.res_en  = 1'b1;
                cmd.res_sel = RES_LOOKUP;
                cmd.wr_en   = sts.op == OP_MARK;
                cmd.wr_sel  = WR_MARK;
                state_next  = S_DONE;
            end
            S_SORT_N:
                if (sts.n_ge)
                begin
                    cmd.n_clr  = 1'b1;
                    state_next = S_REB_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_N;
                    state_next = S_SORT_LD;
                end
            S_SORT_LD:
            begin
                cmd.x_load = 1'b1;
                cmd.m_load = 1'b1;
                state_next = S_SORT_RD;
            end
            S_SORT_RD:
                if (sts.m_zero)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_X;
                    cmd.n_inc  = 1'b1;
                    state_next = S_SORT_N;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_M1;
                    state_next = S_SORT_CMP;
                end
            S_SORT_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (sts.ahead)
                begin
                    cmd.wr_sel = WR_SHIFT;
                    cmd.m_dec  = 1'b1;
                    state_next = S_SORT_RD;
                end
                else
                begin
                    cmd.wr_sel = WR_X;
                    cmd.n_inc  = 1'b1;
                    state_next = S_SORT_N;
                end
            end
            S_REB_RD:
                if (sts.n_ge)
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_SORT;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_N;
                    state_next = S_REB_W;
                end
            S_REB_W:
            begin
                cmd.idx_wr  = 1'b1;
                cmd.idx_sel = IDX_REBUILD;
                cmd.n_inc   = 1'b1;
                state_next  = S_REB_RD;
            end
            S_DONE:
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hdl/spatial_cell_pool_zorder_sort.sv]
// Top level of the z-order sorted cell pool: controller plus datapath.
// Depends on scpz_pkg, scpz_if, scpz_ctrl and scpz_datapath.
//
//  channel | modport | word       | accepted when
//  req     | sink    | req_word_t | req.valid && req.ready
//  rsp     | source  | rsp_word_t | rsp.valid && rsp.ready
//
// Per word: get and mark read the id index and then the slot, or answer an
// unknown id without reading either memory. Create scans the slots in order and
// reuses the first free slot, or, after scanning all count slots, appends or
// finds the pool full. Sort runs an insertion sort over the single-port slot
// memory, moving one element at a time, then rebuilds the index from the slots.
// Reset clears only the cell count and control; memories need no clearing pass.
// A finished word waits in the output register; a new request is taken while it
// waits, and only the hand-off of the next result stalls on rsp.ready.
module spatial_cell_pool_zorder_sort import scpz_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    scpz_req_if.sink  req,
    scpz_rsp_if.source rsp
);

    cmd_t cmd;
    sts_t sts;

    // sequence each operation
    scpz_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // hold the pool, index and result registers
    scpz_datapath #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_data  (req.data),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp.data)
    );

endmodule

[hdl/scpz_checker.sv]
// Port-level assertions for the cell pool, bound to the top level.
// Depends on scpz_pkg and spatial_cell_pool_zorder_sort.
module scpz_checker import scpz_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_word_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response word dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an operation is in progress");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == ST_FULL |->
        rsp_data.cell_id == 8'd0 && rsp_data.slot == 8'd0 && !rsp_data.reused)
        else $error("pool full word carries cell data");

    a_reused_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.reused |-> rsp_data.status == ST_OK)
        else $error("reused slot reported with error status");

endmodule

bind spatial_cell_pool_zorder_sort scpz_checker u_scpz_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

[bench/tb.sv]
// Self-checking bench for the z-order sorted cell pool.
// Depends on scpz_pkg, scpz_if and the top level spatial_cell_pool_zorder_sort.
// A clocked driver and monitor run against a local model of the pool.
module tb;
    import scpz_pkg::*;

    localparam int POOL_CAP   = CAPACITY_DEF;
    localparam int CYCLE_CAP  = 8000000;
    localparam int TAIL_WAIT  = 40;

    logic clk;
    logic rst_n;

    scpz_req_if req ();
    scpz_rsp_if rsp ();

    spatial_cell_pool_zorder_sort uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Local copy of the pool: points, ids, free marks and the id index.
    logic [15:0] cell_pt [POOL_CAP][3];
    int          cell_ident [POOL_CAP];
    bit          cell_free [POOL_CAP];
    int          ident_slot [POOL_CAP];
    int          live_cells;

    req_word_t   pending_words [$];
    rsp_word_t   awaited_words [$];

    int          send_idle_pct;
    int          stall_pct;
    bit          req_taken;
    int          mismatches;
    int          checked;
    int          cycles;
    int          est_cells;
    int          sorts_sent;
    int          fulls_seen;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Unsigned ordering of the most significant set bit.
    function automatic bit msb_lower(logic [15:0] x, logic [15:0] y);
        return (x < y) && (x < (x ^ y));
    endfunction

    // Used cells first, in Morton order of the offset points; ties by id.
    function automatic bit ranks_ahead(int a, int b);
        logic [15:0] pa [3];
        logic [15:0] pb [3];
        int top;
        if (cell_free[a] != cell_free[b])
            return !cell_free[a];
        if (!cell_free[a])
        begin
            for (int d = 0; d < 3; d++)
            begin
                pa[d] = cell_pt[a][d] ^ 16'h8000;
                pb[d] = cell_pt[b][d] ^ 16'h8000;
            end
            top = 0;
            for (int d = 1; d < 3; d++)
                if (msb_lower(pa[top] ^ pb[top], pa[d] ^ pb[d]))
                    top = d;
            if (pa[top] != pb[top])
                return pa[top] < pb[top];
        end
        return cell_ident[a] < cell_ident[b];
    endfunction

    function automatic void swap_cells(int a, int b);
        logic [15:0] tp;
        int ti;
        bit tf;
        for (int d = 0; d < 3; d++)
        begin
            tp = cell_pt[a][d];
            cell_pt[a][d] = cell_pt[b][d];
            cell_pt[b][d] = tp;
        end
        ti = cell_ident[a]; cell_ident[a] = cell_ident[b]; cell_ident[b] = ti;
        tf = cell_free[a]; cell_free[a] = cell_free[b]; cell_free[b] = tf;
    endfunction

    function automatic rsp_word_t cell_report(int s, status_t st, bit reuse);
        rsp_word_t r;
        r.cell_id = cell_ident[s][7:0];
        r.slot    = s[7:0];
        r.out_i   = cell_pt[s][0];
        r.out_j   = cell_pt[s][1];
        r.out_k   = cell_pt[s][2];
        r.reused  = reuse;
        r.status  = st;
        return r;
    endfunction

    // Apply one request to the local pool and return the word it should yield.
    function automatic rsp_word_t pool_apply(req_word_t w);
        rsp_word_t r;
        int n;
        int m;
        int id;
        r  = '0;
        id = int'(w.handle_id);
        if (w.op == OP_SORT)
        begin
            for (n = 1; n < live_cells; n++)
                for (m = n; m > 0 && ranks_ahead(m, m - 1); m--)
                    swap_cells(m, m - 1);
            for (n = 0; n < live_cells; n++)
                ident_slot[cell_ident[n] % POOL_CAP] = n;
            r.status = ST_OK;
            return r;
        end
        if (w.op == OP_CREATE && !w.handle_valid)
        begin
            for (n = 0; n < live_cells; n++)
                if (cell_free[n])
                    break;
            if (n == live_cells)
            begin
                if (live_cells >= POOL_CAP)
                begin
                    r.status = ST_FULL;
                    return r;
                end
                cell_ident[n] = n;
                ident_slot[n] = n;
                live_cells++;
            end
            cell_pt[n][0] = w.point_i;
            cell_pt[n][1] = w.point_j;
            cell_pt[n][2] = w.point_k;
            r = cell_report(n, ST_OK, (n + 1 < live_cells) || cell_free[n]);
            cell_free[n] = 1'b0;
            return r;
        end
        if (id >= live_cells)
        begin
            r.cell_id = w.handle_id;
            r.status  = ST_DANGLING;
            return r;
        end
        n = ident_slot[id] % POOL_CAP;
        if (w.op == OP_CREATE)
            r = cell_report(n, ST_VALID, 1'b0);
        else if (w.op == OP_GET)
            r = cell_report(n, w.handle_valid ? ST_OK : ST_DANGLING, 1'b0);
        else
        begin
            cell_free[n] = w.cell_empty;
            r = cell_report(n, ST_OK, 1'b0);
        end
        return r;
    endfunction

    task automatic queue_word(op_t op, bit hv, int id, int pi, int pj, int pk, bit ce);
        req_word_t w;
        w.op           = op;
        w.handle_valid = hv;
        w.handle_id    = id[7:0];
        w.point_i      = pi[15:0];
        w.point_j      = pj[15:0];
        w.point_k      = pk[15:0];
        w.cell_empty   = ce;
        if (op == OP_CREATE && !hv && est_cells < POOL_CAP)
            est_cells++;
        if (op == OP_SORT)
            sorts_sent++;
        pending_words.push_back(w);
    endtask

    function automatic int pick_coord();
        if ($urandom_range(0, 99) < 30)
            return $urandom_range(0, 8) - 4;
        return $urandom_range(0, 65535);
    endfunction

    // Fill one phase of random traffic; create_pct steers pool growth.
    task automatic queue_random(int count, int create_pct);
        int roll;
        int id;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 85)
                id = $urandom_range(0, est_cells > 0 ? est_cells - 1 : 0);
            else
                id = $urandom_range(0, 255);
            // Keep sorts rare once the pool is large; each one walks it all.
            if ($urandom_range(0, 99) < (est_cells > 64 ? 1 : 6))
                queue_word(OP_SORT, 1'($urandom_range(0, 1)), $urandom_range(0, 255),
                           pick_coord(), pick_coord(), pick_coord(),
                           1'($urandom_range(0, 1)));
            else if (roll < create_pct)
                queue_word(OP_CREATE, $urandom_range(0, 99) < 15, id,
                           pick_coord(), pick_coord(), pick_coord(),
                           1'($urandom_range(0, 1)));
            else if (roll < create_pct + (100 - create_pct) / 2)
                queue_word(OP_GET, 1'($urandom_range(0, 1)), id,
                           pick_coord(), pick_coord(), pick_coord(),
                           1'($urandom_range(0, 1)));
            else
                queue_word(OP_MARK, 1'($urandom_range(0, 1)), id,
                           pick_coord(), pick_coord(), pick_coord(),
                           $urandom_range(0, 99) < 35);
        end
    endtask

    task automatic drain_phase();
        while (pending_words.size() != 0 || awaited_words.size() != 0)
            @(posedge clk);
    endtask

    // Stop a hung run: no response can take this long on a correct block.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d words still awaited",
                     cycles, awaited_words.size());
            $display("FAIL");
            $finish;
        end
    end

    // Sample both channels at the rising edge: predict on each accepted
    // request word, check each accepted response word against the oldest one.
    always @(posedge clk)
    begin
        req_taken = 1'b0;
        if (rst_n && req.valid && req.ready)
        begin
            req_taken = 1'b1;
            awaited_words.push_back(pool_apply(req.data));
            void'(pending_words.pop_front());
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (awaited_words.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word id=%0d slot=%0d st=%0d", $time,
                         rsp.data.cell_id, rsp.data.slot, rsp.data.status);
            end
            else
            begin
                rsp_word_t exp_w;
                exp_w = awaited_words.pop_front();
                checked++;
                if (rsp.data.status == ST_FULL)
                    fulls_seen++;
                if (rsp.data.cell_id !== exp_w.cell_id || rsp.data.slot !== exp_w.slot ||
                    rsp.data.out_i !== exp_w.out_i || rsp.data.out_j !== exp_w.out_j ||
                    rsp.data.out_k !== exp_w.out_k || rsp.data.reused !== exp_w.reused ||
                    rsp.data.status !== exp_w.status)
                begin
                    mismatches++;
                    $display("%0t: expected id=%0d slot=%0d p=(%0d,%0d,%0d) re=%0d st=%0d",
                             $time, exp_w.cell_id, exp_w.slot, exp_w.out_i, exp_w.out_j,
                             exp_w.out_k, exp_w.reused, exp_w.status);
                    $display("%0t: actual   id=%0d slot=%0d p=(%0d,%0d,%0d) re=%0d st=%0d",
                             $time, rsp.data.cell_id, rsp.data.slot, rsp.data.out_i,
                             rsp.data.out_j, rsp.data.out_k, rsp.data.reused,
                             rsp.data.status);
                end
            end
        end
    end

    // Drive at the falling edge. Hold a word until it is taken; otherwise
    // advance to the next pending word or idle, as the phase asks.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (!(req.valid && !req_taken))
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req.valid <= 1'b1;
                    req.data  <= pending_words[0];
                end
                else
                    req.valid <= 1'b0;
            end
            rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        req.valid     = 1'b0;
        req.data      = '0;
        rsp.ready     = 1'b0;
        rst_n         = 1'b0;
        req_taken     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        mismatches    = 0;
        checked       = 0;
        cycles        = 0;
        est_cells     = 0;
        sorts_sent    = 0;
        fulls_seen    = 0;
        live_cells    = 0;
        for (int n = 0; n < POOL_CAP; n++)
        begin
            cell_pt[n][0] = '0;
            cell_pt[n][1] = '0;
            cell_pt[n][2] = '0;
            cell_ident[n] = 0;
            cell_free[n]  = 1'b0;
            ident_slot[n] = 0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-pool lookups, coordinate extremes, reuse, sort.
        queue_word(OP_GET, 1, 0, 0, 0, 0, 0);
        queue_word(OP_SORT, 0, 0, 0, 0, 0, 0);
        queue_word(OP_CREATE, 0, 0, -32768, -32768, -32768, 0);
        queue_word(OP_CREATE, 0, 0, 32767, 32767, 32767, 1);
        queue_word(OP_CREATE, 0, 0, 0, -1, 0, 0);
        queue_word(OP_CREATE, 0, 0, -1, 0, 1, 0);
        queue_word(OP_CREATE, 0, 0, 0, -1, 0, 0);
        queue_word(OP_CREATE, 1, 1, 5, 5, 5, 0);
        queue_word(OP_CREATE, 1, 255, 5, 5, 5, 0);
        queue_word(OP_GET, 1, 2, 0, 0, 0, 0);
        queue_word(OP_GET, 0, 3, 0, 0, 0, 0);
        queue_word(OP_GET, 1, 255, 0, 0, 0, 0);
        queue_word(OP_MARK, 0, 1, 0, 0, 0, 1);
        queue_word(OP_MARK, 1, 3, 0, 0, 0, 1);
        queue_word(OP_MARK, 1, 200, 0, 0, 0, 1);
        queue_word(OP_SORT, 1, 255, -1, -1, -1, 1);
        queue_word(OP_GET, 1, 1, 0, 0, 0, 0);
        queue_word(OP_GET, 1, 4, 0, 0, 0, 0);
        queue_word(OP_CREATE, 0, 0, 100, -100, 7, 0);
        queue_word(OP_CREATE, 0, 0, -7, 12, -300, 0);
        queue_word(OP_MARK, 1, 0, 0, 0, 0, 0);
        queue_word(OP_SORT, 0, 0, 0, 0, 0, 0);
        queue_word(OP_GET, 1, 0, 0, 0, 0, 0);
        drain_phase();

        // Random phases under each idling pattern; the later ones fill the pool.
        queue_random(230, 45);
        drain_phase();
        send_idle_pct = 77;
        queue_random(230, 50);
        drain_phase();
        send_idle_pct = 0;
        stall_pct     = 77;
        queue_random(230, 60);
        drain_phase();
        send_idle_pct = 16;
        stall_pct     = 16;
        queue_random(230, 70);
        drain_phase();
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_random(230, 55);
        drain_phase();

        repeat (TAIL_WAIT) @(posedge clk);
        $display("checked %0d response words, %0d sorts, %0d pool-full replies",
                 checked, sorts_sent, fulls_seen);
        $display("pool ended with %0d cells, %0d mismatches", live_cells, mismatches);
        if (mismatches == 0 && awaited_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
